/* src/ssot_pkg.sv */
// Shared types and fixed constants for the servo sweep / over-current trip block.
// No dependencies; every other file in src except ssot_checker uses this package.
package ssot_pkg;

  localparam int PULSE_W    = 12;
  localparam int CUR_W      = 18;
  localparam int CUTOFF_W   = 17;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;

  // Two-entry queue between the front and the back.
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // Readings above 78 A are treated as sensor glitches and enter the window as 0.
  localparam logic signed [CUR_W-1:0] READ_LIMIT_MA = 18'sd78000;

  localparam logic [PULSE_W-1:0]  OPEN_PULSE_RST   = 12'd930;
  localparam logic [PULSE_W-1:0]  CLOSED_PULSE_RST = 12'd2010;
  localparam logic [CUTOFF_W-1:0] CUTOFF_RST       = 17'd2400;

  typedef enum logic {
    FUNC_START  = 1'b0,
    FUNC_SAMPLE = 1'b1
  } func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OPEN_PULSE   = 2'd0,
    CFG_CLOSED_PULSE = 2'd1,
    CFG_CUTOFF       = 2'd2
  } cfg_idx_t;

  // Classified word as it sits in the queue.
  typedef struct packed {
    func_t                    func;
    logic                     target_open;
    logic                     hold;
    logic signed [CUR_W-1:0]  sample;   // already screened against the read limit
  } op_t;

endpackage

/* src/ssot_ifs.sv */
// Valid/ready channel interfaces for the input and result words.
// Depends on ssot_pkg for field widths.
interface ssot_in_if;
  logic                              valid;
  logic                              ready;
  logic                              func;
  logic                              target_open;
  logic                              hold;
  logic signed [ssot_pkg::CUR_W-1:0] current_ma;

  modport source (output valid, func, target_open, hold, current_ma, input ready);
  modport sink   (input valid, func, target_open, hold, current_ma, output ready);
endinterface

interface ssot_out_if;
  logic                          valid;
  logic                          ready;
  logic [ssot_pkg::PULSE_W-1:0]  pulse_us;
  logic                          drive_on;
  logic                          sweep_done;
  logic                          over_current;

  modport source (output valid, pulse_us, drive_on, sweep_done, over_current, input ready);
  modport sink   (input valid, pulse_us, drive_on, sweep_done, over_current, output ready);
endinterface

/* src/servo_sweep_overcurrent_trip.sv */
// Top level of the servo sweep with averaged over-current trip.
// Depends on ssot_pkg, ssot_ifs, ssot_front, ssot_queue and ssot_back.
//
//   channel  | dir | handshake          | payload
//   ---------+-----+--------------------+------------------------------------------
//   in_ch    | in  | valid/ready        | func, target_open, hold, current_ma
//   out_ch   | out | valid/ready        | pulse_us, drive_on, sweep_done, over_current
//   cfg_*    | in  | cfg_we, no stall   | cfg_index, cfg_data (open, closed, cutoff)
//
// One word in and one result out per cycle when neither side stalls; a word passes
// the front register, the two-entry queue and the result register in turn.
// The rate is set by the back stage, which updates window, trip compare and ramp
// point for one word per cycle; the ramp divide is a single reciprocal multiply.
// rst_n is synchronous, active low; no clearing pass, the block is ready on the
// first cycle after reset.
// A stall on out_ch fills the result register, then the queue, then the front
// register before in_ch.ready drops; each side can stall on its own.
module servo_sweep_overcurrent_trip #(
  parameter int SWEEP_STEPS = 120,
  parameter int AVG_WINDOW  = 5
) (
  input  logic                            clk,
  input  logic                            rst_n,
  ssot_in_if.sink                         in_ch,
  ssot_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [ssot_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ssot_pkg::CFG_DATA_W-1:0] cfg_data
);
  import ssot_pkg::*;

  logic push_valid, push_ready;
  op_t  push_op;
  logic pop_valid, pop_ready;
  op_t  pop_op;

  // decode and screen incoming words
  ssot_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_op    (push_op)
  );

  // decouples the front from back-pressure on out_ch
  ssot_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_op    (push_op),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_op     (pop_op)
  );

  // sweep state machine data path and result register
  ssot_back #(
    .SWEEP_STEPS (SWEEP_STEPS),
    .AVG_WINDOW  (AVG_WINDOW)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_valid   (pop_valid),
    .q_ready   (pop_ready),
    .q_op      (pop_op),
    .out_ch    (out_ch)
  );

endmodule

/* src/ssot_front.sv */
// Front stage: accepts input words, decodes func and screens the current reading.
// Depends on ssot_pkg and ssot_in_if.
module ssot_front (
  input  logic         clk,
  input  logic         rst_n,
  ssot_in_if.sink      in_ch,
  output logic         push_valid,
  input  logic         push_ready,
  output ssot_pkg::op_t push_op
);
  import ssot_pkg::*;

  logic ent_valid_r, ent_valid_nxt;
  op_t  ent_r, ent_nxt;
  logic accept;

  assign in_ch.ready = !ent_valid_r || push_ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign push_valid  = ent_valid_r;
  assign push_op     = ent_r;

  always_comb begin
    ent_nxt             = ent_r;
    ent_valid_nxt       = ent_valid_r;
    if (accept) begin
      ent_valid_nxt       = 1'b1;
      ent_nxt.func        = (in_ch.func == FUNC_SAMPLE) ? FUNC_SAMPLE : FUNC_START;
      ent_nxt.target_open = in_ch.target_open;
      ent_nxt.hold        = in_ch.hold;
      ent_nxt.sample      = (in_ch.current_ma > READ_LIMIT_MA) ? '0 : in_ch.current_ma;
    end else if (push_ready) begin
      ent_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_valid_r <= 1'b0;
    end else begin
      ent_valid_r <= ent_valid_nxt;
    end
    ent_r <= ent_nxt;
  end

endmodule

/* src/ssot_queue.sv */
// Short FIFO between front and back; push and pop may happen in the same cycle.
// Depends on ssot_pkg.
module ssot_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  output logic          push_ready,
  input  ssot_pkg::op_t push_op,
  output logic          pop_valid,
  input  logic          pop_ready,
  output ssot_pkg::op_t pop_op
);
  import ssot_pkg::*;

  op_t                mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_CNT_W-1:0] count_r;
  logic               do_push, do_pop;

  assign push_ready = (count_r != Q_CNT_W'(Q_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_op     = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_op;
    end
  end

endmodule

/* src/ssot_back.sv */
// Back stage: sweep state, moving-average trip and ramp, plus the result register.
// Depends on ssot_pkg and ssot_out_if.
module ssot_back #(
  parameter int SWEEP_STEPS = 120,
  parameter int AVG_WINDOW  = 5
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [ssot_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ssot_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             q_valid,
  output logic                             q_ready,
  input  ssot_pkg::op_t                    q_op,
  ssot_out_if.source                       out_ch
);
  import ssot_pkg::*;

  localparam int STEP_W  = $clog2(SWEEP_STEPS + 1);
  localparam int PROD_W  = PULSE_W + STEP_W;            // |delta| * step
  localparam int SHIFT   = PROD_W + $clog2(SWEEP_STEPS);
  localparam int RECIP_W = PROD_W + 1;
  localparam int MUL_W   = PROD_W + RECIP_W;
  // ceil(2^SHIFT / STEPS): exact floor division for any PROD_W-bit dividend
  localparam longint unsigned RECIP =
    ((longint'(1) << SHIFT) + SWEEP_STEPS - 1) / SWEEP_STEPS;
  localparam int SLOT_W  = (AVG_WINDOW > 1) ? $clog2(AVG_WINDOW) : 1;
  localparam int SUM_W   = CUR_W + $clog2(AVG_WINDOW) + 1;
  localparam int LIM_W   = CUTOFF_W + $clog2(AVG_WINDOW + 1);
  localparam int CMP_W   = ((SUM_W > LIM_W) ? SUM_W : LIM_W) + 1;

  // configuration
  logic [PULSE_W-1:0] open_r, closed_r;
  logic [LIM_W-1:0]   limit_r;           // cutoff * window length

  // sweep state
  logic [PULSE_W-1:0] last_r, last_nxt;
  logic               known_r, known_nxt;
  logic [PULSE_W-1:0] start_r, start_nxt;
  logic               neg_r, neg_nxt;
  logic [PULSE_W-1:0] mag_r, mag_nxt;
  logic [PROD_W-1:0]  prod_r, prod_nxt;
  logic [STEP_W-1:0]  step_r, step_nxt;
  logic               active_r, active_nxt;
  logic               hold_r, hold_nxt;
  logic               drive_r, drive_nxt;
  logic signed [CUR_W-1:0] win_r [AVG_WINDOW];
  logic signed [CUR_W-1:0] win_nxt [AVG_WINDOW];
  logic signed [SUM_W-1:0] sum_r, sum_nxt;
  logic [SLOT_W-1:0]  slot_r, slot_nxt;

  // result register
  logic               ovalid_r, ovalid_nxt;
  logic               done_nxt, trip_nxt;
  logic               done_r, trip_r;

  logic               exec;
  logic [PULSE_W-1:0] end_pulse, from_pulse;
  logic signed [PULSE_W:0]   diff;
  logic signed [SUM_W-1:0]   sum_upd;
  logic signed [CMP_W-1:0]   sum_cmp, lim_cmp;
  logic [MUL_W-1:0]          mul_full;
  logic [PULSE_W-1:0]        quot;
  logic signed [PULSE_W+1:0] pulse_s;
  logic [PULSE_W-1:0]        pulse_sat;

  assign q_ready = !ovalid_r || out_ch.ready;
  assign exec    = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r   <= OPEN_PULSE_RST;
      closed_r <= CLOSED_PULSE_RST;
      limit_r  <= LIM_W'(CUTOFF_RST) * LIM_W'(AVG_WINDOW);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_OPEN_PULSE:   open_r   <= cfg_data[PULSE_W-1:0];
        CFG_CLOSED_PULSE: closed_r <= cfg_data[PULSE_W-1:0];
        CFG_CUTOFF:       limit_r  <= LIM_W'(cfg_data[CUTOFF_W-1:0]) * LIM_W'(AVG_WINDOW);
        default: ;
      endcase
    end
  end

  // start path
  assign end_pulse  = q_op.target_open ? open_r : closed_r;
  assign from_pulse = known_r ? last_r : closed_r;
  assign diff       = $signed({1'b0, end_pulse}) - $signed({1'b0, from_pulse});

  // sample path: window update and trip compare
  assign sum_upd = sum_r - SUM_W'(win_r[slot_r]) + SUM_W'(q_op.sample);
  assign sum_cmp = CMP_W'(sum_upd);
  assign lim_cmp = CMP_W'(limit_r);

  // ramp: |delta|*i / STEPS by reciprocal multiply, truncated toward zero
  assign mul_full = prod_r * RECIP_W'(RECIP);
  assign quot     = mul_full[SHIFT +: PULSE_W];
  assign pulse_s  = neg_r ? ($signed({2'b00, start_r}) - $signed({2'b00, quot}))
                          : ($signed({2'b00, start_r}) + $signed({2'b00, quot}));

  always_comb begin
    if (pulse_s < 0) begin
      pulse_sat = '0;
    end else if (pulse_s > $signed({2'b00, {PULSE_W{1'b1}}})) begin
      pulse_sat = '1;
    end else begin
      pulse_sat = pulse_s[PULSE_W-1:0];
    end
  end

  always_comb begin
    last_nxt   = last_r;
    known_nxt  = known_r;
    start_nxt  = start_r;
    neg_nxt    = neg_r;
    mag_nxt    = mag_r;
    prod_nxt   = prod_r;
    step_nxt   = step_r;
    active_nxt = active_r;
    hold_nxt   = hold_r;
    drive_nxt  = drive_r;
    win_nxt    = win_r;
    sum_nxt    = sum_r;
    slot_nxt   = slot_r;
    done_nxt   = 1'b0;
    trip_nxt   = 1'b0;
    ovalid_nxt = ovalid_r && !out_ch.ready;

    if (exec) begin
      ovalid_nxt = 1'b1;
      if (q_op.func == FUNC_START) begin
        start_nxt  = from_pulse;
        neg_nxt    = diff[PULSE_W];
        mag_nxt    = diff[PULSE_W] ? PULSE_W'(-diff) : diff[PULSE_W-1:0];
        prod_nxt   = '0;
        step_nxt   = '0;
        active_nxt = 1'b1;
        hold_nxt   = q_op.hold;
        for (int i = 0; i < AVG_WINDOW; i++) begin
          win_nxt[i] = '0;
        end
        sum_nxt    = '0;
        slot_nxt   = '0;
      end else if (active_r) begin
        win_nxt[slot_r] = q_op.sample;
        sum_nxt         = sum_upd;
        slot_nxt        = (slot_r == SLOT_W'(AVG_WINDOW - 1)) ? '0 : slot_r + 1'b1;
        if (sum_cmp > lim_cmp) begin
          drive_nxt  = 1'b0;
          active_nxt = 1'b0;
          done_nxt   = 1'b1;
          trip_nxt   = 1'b1;
        end else begin
          last_nxt  = pulse_sat;
          known_nxt = 1'b1;
          drive_nxt = 1'b1;
          step_nxt  = step_r + 1'b1;
          prod_nxt  = prod_r + PROD_W'(mag_r);
          if (step_r == STEP_W'(SWEEP_STEPS - 1)) begin
            active_nxt = 1'b0;
            done_nxt   = 1'b1;
            drive_nxt  = hold_r;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r   <= '0;
      known_r  <= 1'b0;
      start_r  <= '0;
      neg_r    <= 1'b0;
      mag_r    <= '0;
      prod_r   <= '0;
      step_r   <= '0;
      active_r <= 1'b0;
      hold_r   <= 1'b0;
      drive_r  <= 1'b0;
      for (int i = 0; i < AVG_WINDOW; i++) begin
        win_r[i] <= '0;
      end
      sum_r    <= '0;
      slot_r   <= '0;
      ovalid_r <= 1'b0;
    end else begin
      last_r   <= last_nxt;
      known_r  <= known_nxt;
      start_r  <= start_nxt;
      neg_r    <= neg_nxt;
      mag_r    <= mag_nxt;
      prod_r   <= prod_nxt;
      step_r   <= step_nxt;
      active_r <= active_nxt;
      hold_r   <= hold_nxt;
      drive_r  <= drive_nxt;
      win_r    <= win_nxt;
      sum_r    <= sum_nxt;
      slot_r   <= slot_nxt;
      ovalid_r <= ovalid_nxt;
    end
    if (exec) begin
      done_r <= done_nxt;
      trip_r <= trip_nxt;
    end
  end

  // pulse/drive fields are the post-update state, which the state registers hold
  assign out_ch.valid        = ovalid_r;
  assign out_ch.pulse_us     = last_r;
  assign out_ch.drive_on     = drive_r;
  assign out_ch.sweep_done   = done_r;
  assign out_ch.over_current = trip_r;

endmodule

/* src/ssot_checker.sv */
// Port-level checks for the servo sweep block, bound to the top level.
// Depends only on the top level's ports.
module ssot_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [11:0] pulse_us,
  input logic        drive_on,
  input logic        sweep_done,
  input logic        over_current
);

  // a trip always ends the sweep
  a_trip_ends_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && over_current |-> sweep_done)
    else $error("over_current without sweep_done");

  // a trip always leaves the drive off
  a_trip_drive_off: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && over_current |-> !drive_on)
    else $error("drive still on after trip");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(pulse_us) && $stable(drive_on)
      && $stable(sweep_done) && $stable(over_current))
    else $error("result changed while stalled");

  // no result in the cycle after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind servo_sweep_overcurrent_trip ssot_checker u_ssot_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .pulse_us     (out_ch.pulse_us),
  .drive_on     (out_ch.drive_on),
  .sweep_done   (out_ch.sweep_done),
  .over_current (out_ch.over_current)
);
